[rtl/core/tmr_pkg.sv]
`timescale 1ns / 1ps
package tmr_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int DEFER_SLOTS = 16;

  // Width of a task position, of a task count that can hold TASK_SLOTS, and of
  // a deferred-entry count that can hold DEFER_SLOTS.
  localparam int TIW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TCW = $clog2(TASK_SLOTS + 1);
  localparam int DCW = $clog2(DEFER_SLOTS + 1);

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_REGISTER     = 3'd1,
    OP_START        = 3'd2,
    OP_STOP         = 3'd3,
    OP_ADD_DELAY    = 3'd4,
    OP_DEFER_APPEND = 3'd5,
    OP_DEFER_HEAD   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    RK_PERIODIC    = 2'd0,
    RK_DEFERRED    = 2'd1,
    RK_REG_REPLY   = 2'd2,
    RK_DEFER_REPLY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TASKS,
    ST_DEFERS,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic        en;
    logic [31:0] period;
    logic [31:0] count;
  } task_ent_t;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] count;
    logic [7:0]  handle;
  } defer_ent_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } task_ctl_t;

  typedef struct packed {
    logic shl;
    logic shr;
    logic wr;
  } defer_ctl_t;

  // Signed a >= signed b on 32-bit words.
  function automatic logic sge(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) >= $signed(b);
  endfunction

endpackage

[rtl/core/tmr_task_cell.sv]
`timescale 1ns / 1ps
module tmr_task_cell (
  input  logic               clk,
  input  logic               rst,
  input  tmr_pkg::task_ctl_t ctl,
  input  tmr_pkg::task_ent_t nb,
  input  tmr_pkg::task_ent_t wr_data,
  output tmr_pkg::task_ent_t ent
);
  import tmr_pkg::*;

  logic        en;
  logic [31:0] period;
  logic [31:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      en <= 1'b0;
    end else if (ctl.shift) begin
      en <= nb.en;
    end else if (ctl.wr) begin
      en <= wr_data.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      period <= nb.period;
      count  <= nb.count;
    end else if (ctl.wr) begin
      period <= wr_data.period;
      count  <= wr_data.count;
    end
  end

  assign ent = '{en: en, period: period, count: count};

endmodule

[rtl/core/tmr_defer_cell.sv]
`timescale 1ns / 1ps
module tmr_defer_cell (
  input  logic                clk,
  input  tmr_pkg::defer_ctl_t ctl,
  input  tmr_pkg::defer_ent_t nb_hi,
  input  tmr_pkg::defer_ent_t nb_lo,
  input  tmr_pkg::defer_ent_t wr_data,
  output tmr_pkg::defer_ent_t ent
);
  import tmr_pkg::*;

  // A direct write wins over a shift so that a kept entry can land at the
  // tail while the list moves toward the head.
  always_ff @(posedge clk) begin
    priority if (ctl.wr) begin
      ent <= wr_data;
    end else if (ctl.shl) begin
      ent <= nb_hi;
    end else if (ctl.shr) begin
      ent <= nb_lo;
    end
  end

endmodule

[rtl/core/periodic_and_oneshot_task_timer_top.sv]
`timescale 1ns / 1ps
// Periodic and one-shot task timer.
// Input items arrive on the s_axis channel: tuser carries the operation and
// tdata its operands. Result items leave on the m_axis channel: tuser gives
// the result kind, tdata the index and the accepted flag, and tlast marks the
// final result that an input item causes.
// The periodic tasks sit in a row of cells that rotates by one cell per
// cycle during a tick unless the output stalls; the task at the head is
// updated by one shared adder and compare. The deferred list sits in a
// second row of cells kept in firing order; during a tick its head is popped
// each cycle unless the output stalls and, unless it fires, written back at
// the tail. A tick with forward time runs the task pass, then the deferred
// pass and a flush step before the next item is taken; register and defer
// operations run only the flush step, all others none.
// The block takes one item at a time: s_axis_tready is high only while idle.
// Reset clears the time, the registration count, the enable bits and the
// deferred list; no clearing pass is needed.
// When the receiver stalls, the results wait in an output register and one
// pending register and the passes halt until room frees up; nothing is lost.
module periodic_and_oneshot_task_timer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_time[31:0], task_number[35:32], period_length[66:36],
  // delay_amount[97:67], enable_now[98], handle[106:99], zero above
  input  logic [111:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_index[7:0], accepted[8], zero above
  output logic [15:0]  m_axis_tdata,
  // result_kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import tmr_pkg::*;

  state_t state, state_next;

  logic [31:0]  prev_time;
  logic [31:0]  delta;
  logic [TCW-1:0] tasks_reg;
  logic [DCW-1:0] used;
  logic [DCW-1:0] rem;
  logic [TIW-1:0] tpos;

  logic        pend_valid;
  kind_t       pend_kind;
  logic [7:0]  pend_index;
  logic        pend_acc;

  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_index;
  logic        out_acc;
  logic        out_last;

  // Input decode.
  op_t         op;
  logic [31:0] in_now;
  logic [3:0]  in_task;
  logic [30:0] in_period;
  logic [30:0] in_delay;
  logic        in_en;
  logic [7:0]  in_handle;
  logic [31:0] dz;
  logic        take;
  logic        adv;
  logic [31:0] delta_in;
  logic        delta_ok;
  logic        id_valid;
  logic [3:0]  id_idx;
  logic        defer_room;

  assign op        = op_t'(s_axis_tuser);
  assign in_now    = s_axis_tdata[31:0];
  assign in_task   = s_axis_tdata[35:32];
  assign in_period = s_axis_tdata[66:36];
  assign in_delay  = s_axis_tdata[97:67];
  assign in_en     = s_axis_tdata[98];
  assign in_handle = s_axis_tdata[106:99];
  assign dz        = {1'b0, in_delay};

  assign s_axis_tready = (state == ST_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign adv           = !out_valid || m_axis_tready;
  assign delta_in      = in_now - prev_time;
  assign delta_ok      = (delta_in != 32'd0) && !delta_in[31];
  assign id_idx        = in_task - 4'd1;
  assign id_valid      = (in_task != 4'd0) && (32'(id_idx) < 32'(TASK_SLOTS));
  assign defer_room    = (32'(used) < 32'(DEFER_SLOTS));

  // Periodic task row.
  task_ent_t tent [TASK_SLOTS];
  task_ent_t tnb  [TASK_SLOTS];
  task_ent_t twd  [TASK_SLOTS];
  task_ctl_t tctl [TASK_SLOTS];

  logic        task_step;
  logic [31:0] tsum;
  logic        tact;
  logic        tfire;
  task_ent_t   trot;

  assign task_step = (state == ST_TASKS) && adv;
  assign tsum      = tent[0].count + delta;
  assign tact      = (TCW'(tpos) < tasks_reg) && tent[0].en;
  assign tfire     = tact && sge(tsum, tent[0].period);

  always_comb begin
    trot = tent[0];
    if (tact) begin
      trot.count = tfire ? 32'd0 : tsum;
    end
  end

  // Deferred list row.
  defer_ent_t dent [DEFER_SLOTS];
  defer_ent_t dhi  [DEFER_SLOTS];
  defer_ent_t dlo  [DEFER_SLOTS];
  defer_ent_t dwd  [DEFER_SLOTS];
  defer_ctl_t dctl [DEFER_SLOTS];

  logic        defer_step;
  logic [31:0] dsum;
  logic        dfire;

  assign defer_step = (state == ST_DEFERS) && adv && (rem != '0);
  assign dsum       = dent[0].count + delta;
  assign dfire      = sge(dsum, dent[0].delay);

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_task
    if (i == TASK_SLOTS - 1) begin : g_end
      assign tnb[i] = trot;
    end else begin : g_mid
      assign tnb[i] = tent[i+1];
    end

    always_comb begin
      tctl[i].shift = task_step;
      tctl[i].wr    = 1'b0;
      twd[i]        = tent[i];
      if (take) begin
        unique case (op)
          OP_REGISTER: begin
            if ((32'(tasks_reg) < 32'(TASK_SLOTS)) && (tasks_reg == TCW'(i))) begin
              tctl[i].wr    = 1'b1;
              twd[i].en     = in_en;
              twd[i].period = {1'b0, in_period};
              twd[i].count  = 32'd0 - dz;
            end
          end
          OP_START: begin
            if (id_valid && (32'(id_idx) == 32'(i))) begin
              tctl[i].wr   = 1'b1;
              twd[i].en    = 1'b1;
              twd[i].count = 32'd0 - dz;
            end
          end
          OP_STOP: begin
            if (id_valid && (32'(id_idx) == 32'(i))) begin
              tctl[i].wr = 1'b1;
              twd[i].en  = 1'b0;
            end
          end
          OP_ADD_DELAY: begin
            if (id_valid && (32'(id_idx) == 32'(i))) begin
              tctl[i].wr   = 1'b1;
              twd[i].count = tent[i].count - dz;
            end
          end
          default: begin
          end
        endcase
      end
    end

    tmr_task_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (tctl[i]),
      .nb      (tnb[i]),
      .wr_data (twd[i]),
      .ent     (tent[i])
    );
  end

  for (genvar i = 0; i < DEFER_SLOTS; i++) begin : g_defer
    if (i == DEFER_SLOTS - 1) begin : g_hi_end
      assign dhi[i] = dent[i];
    end else begin : g_hi_mid
      assign dhi[i] = dent[i+1];
    end
    if (i == 0) begin : g_lo_end
      assign dlo[i] = dent[i];
    end else begin : g_lo_mid
      assign dlo[i] = dent[i-1];
    end

    always_comb begin
      dctl[i].shl = defer_step;
      dctl[i].shr = take && (op == OP_DEFER_HEAD) && defer_room;
      dctl[i].wr  = 1'b0;
      dwd[i]      = dent[i];
      if (defer_step && !dfire && ((used - DCW'(1)) == DCW'(i))) begin
        dctl[i].wr = 1'b1;
        dwd[i]     = '{delay: dent[0].delay, count: dsum, handle: dent[0].handle};
      end else if (take && defer_room) begin
        if ((op == OP_DEFER_APPEND) && (used == DCW'(i))) begin
          dctl[i].wr = 1'b1;
          dwd[i]     = '{delay: dz, count: 32'd0, handle: in_handle};
        end else if ((op == OP_DEFER_HEAD) && (i == 0)) begin
          dctl[i].wr = 1'b1;
          dwd[i]     = '{delay: dz, count: dz + 32'd1, handle: in_handle};
        end
      end
    end

    tmr_defer_cell u_cell (
      .clk     (clk),
      .ctl     (dctl[i]),
      .nb_hi   (dhi[i]),
      .nb_lo   (dlo[i]),
      .wr_data (dwd[i]),
      .ent     (dent[i])
    );
  end

  // Result produced by a pass step.
  logic       new_res;
  kind_t      new_kind;
  logic [7:0] new_index;

  always_comb begin
    new_res   = 1'b0;
    new_kind  = RK_PERIODIC;
    new_index = 8'd0;
    if (task_step && tfire) begin
      new_res   = 1'b1;
      new_index = 8'(tpos) + 8'd1;
    end else if (defer_step && dfire) begin
      new_res   = 1'b1;
      new_kind  = RK_DEFERRED;
      new_index = dent[0].handle;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (op)
            OP_TICK:         state_next = delta_ok ? ST_TASKS : ST_IDLE;
            OP_REGISTER,
            OP_DEFER_APPEND,
            OP_DEFER_HEAD:   state_next = ST_FLUSH;
            default:         state_next = ST_IDLE;
          endcase
        end
      end
      ST_TASKS: begin
        if (adv && (tpos == TIW'(TASK_SLOTS - 1))) begin
          state_next = ST_DEFERS;
        end
      end
      ST_DEFERS: begin
        if (rem == '0) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and time.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= 32'd0;
      tasks_reg <= '0;
      used      <= '0;
      rem       <= '0;
      tpos      <= '0;
    end else begin
      if (take) begin
        unique case (op)
          OP_TICK: begin
            if (delta_ok) begin
              prev_time <= in_now;
            end
            tpos <= '0;
          end
          OP_REGISTER: begin
            if (32'(tasks_reg) < 32'(TASK_SLOTS)) begin
              tasks_reg <= tasks_reg + TCW'(1);
            end
          end
          OP_DEFER_APPEND,
          OP_DEFER_HEAD: begin
            if (defer_room) begin
              used <= used + DCW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (task_step) begin
        tpos <= tpos + TIW'(1);
        if (tpos == TIW'(TASK_SLOTS - 1)) begin
          rem <= used;
        end
      end
      if (defer_step) begin
        rem <= rem - DCW'(1);
        if (dfire) begin
          used <= used - DCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (op == OP_TICK)) begin
      delta <= delta_in;
    end
  end

  // Pending result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (take && (op == OP_REGISTER)) begin
        pend_valid <= 1'b1;
        pend_kind  <= RK_REG_REPLY;
        pend_index <= (32'(tasks_reg) < 32'(TASK_SLOTS)) ? 8'(tasks_reg) + 8'd1 : 8'd0;
        pend_acc   <= 1'b0;
      end else if (take && ((op == OP_DEFER_APPEND) || (op == OP_DEFER_HEAD))) begin
        pend_valid <= 1'b1;
        pend_kind  <= RK_DEFER_REPLY;
        pend_index <= in_handle;
        pend_acc   <= defer_room;
      end else if (new_res) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_kind  <= pend_kind;
          out_index <= pend_index;
          out_acc   <= pend_acc;
          out_last  <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_kind  <= new_kind;
        pend_index <= new_index;
        pend_acc   <= 1'b0;
      end else if ((state == ST_FLUSH) && pend_valid && adv) begin
        out_valid  <= 1'b1;
        out_kind   <= pend_kind;
        out_index  <= pend_index;
        out_acc    <= pend_acc;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_acc, out_index};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= 32'(DEFER_SLOTS))
    else $error("deferred list count exceeds its capacity");

  a_tasks_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tasks_reg) <= 32'(TASK_SLOTS))
    else $error("task registration count exceeds its capacity");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending result left behind while idle");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEFERS) |-> (rem <= used))
    else $error("deferred pass has more steps left than entries");
`endif

endmodule
